/* design/vna_pkg.sv */
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int SUM_W = 22;
  localparam int NRM_W = 16;
  localparam int VEC_W = 36;
  localparam int MAG_W = 30;
  localparam int FRAC_W = 14;
  localparam int UNIT_ONE = 16384;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    miss;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } cmd_t;

  typedef logic signed [VEC_W-1:0] vcomp_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
    logic                    nz;
  } unit_res_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] i);
    return int'(i) < VERTEX_COUNT;
  endfunction

endpackage

/* design/vna_front.sv */
module vna_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic [vna_pkg::IDX_W-1:0]           vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]    pos_z,
  input  logic [vna_pkg::IDX_W-1:0]           corner_a,
  input  logic [vna_pkg::IDX_W-1:0]           corner_b,
  input  logic [vna_pkg::IDX_W-1:0]           corner_c,
  output logic                                deq_valid,
  input  logic                                deq_ready,
  output vna_pkg::cmd_t                       deq_cmd
);

  vna_pkg::cmd_t queue [vna_pkg::QDEPTH];
  logic [vna_pkg::QPTR_W-1:0] wr_ptr;
  logic [vna_pkg::QPTR_W-1:0] rd_ptr;
  logic [vna_pkg::QPTR_W:0] count;
  logic keep;
  logic push;
  logic pop;
  vna_pkg::cmd_t cmd_new;

  always_comb begin
    cmd_new.op = vna_pkg::op_t'(kind);
    cmd_new.miss = !vna_pkg::idx_ok(vertex_index);
    cmd_new.idx = vertex_index;
    cmd_new.a = corner_a;
    cmd_new.b = corner_b;
    cmd_new.c = corner_c;
    cmd_new.x = pos_x;
    cmd_new.y = pos_y;
    cmd_new.z = pos_z;
    case (kind)
      vna_pkg::OP_WRITE: keep = vna_pkg::idx_ok(vertex_index);
      vna_pkg::OP_TRI: keep = vna_pkg::idx_ok(corner_a) && vna_pkg::idx_ok(corner_b) &&
                              vna_pkg::idx_ok(corner_c);
      vna_pkg::OP_READ: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = count != (vna_pkg::QPTR_W+1)'(vna_pkg::QDEPTH);
  assign deq_valid = count != '0;
  assign deq_cmd = queue[rd_ptr];
  assign push = in_valid && in_ready && keep;
  assign pop = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (vna_pkg::QPTR_W+1)'(vna_pkg::QDEPTH))
    else $error("queue count above depth");

endmodule

/* design/vna_unit.sv */
module vna_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vna_pkg::vcomp_t    vx,
  input  vna_pkg::vcomp_t    vy,
  input  vna_pkg::vcomp_t    vz,
  output logic               done,
  output vna_pkg::unit_res_t res
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_NORM = 5'b00010,
    U_SQ   = 5'b00100,
    U_ROOT = 5'b01000,
    U_DIV  = 5'b10000
  } ustate_t;

  ustate_t state;
  logic [vna_pkg::VEC_W-1:0] mag [3];
  logic [2:0] neg;
  logic [1:0] cnt;
  logic [3:0] di;
  logic [2*vna_pkg::MAG_W-1:0] sq;
  logic [2*vna_pkg::MAG_W+1:0] acc;
  logic [2*vna_pkg::MAG_W+1:0] rs;
  logic [2*vna_pkg::MAG_W+1:0] rr;
  logic [2*vna_pkg::MAG_W+1:0] rb;
  logic [2*vna_pkg::MAG_W+1:0] trial;
  logic [vna_pkg::MAG_W+vna_pkg::FRAC_W+1:0] rem;
  logic [vna_pkg::MAG_W+vna_pkg::FRAC_W+1:0] dv;
  logic [vna_pkg::FRAC_W:0] quot;
  logic [vna_pkg::FRAC_W:0] qn;
  logic [31:0] len;
  logic big;
  logic allzero;
  logic rem_ge;
  logic [vna_pkg::NRM_W-1:0] qclip;
  logic [vna_pkg::NRM_W-1:0] nval;

  always_comb begin
    big = (|mag[0][vna_pkg::VEC_W-1:vna_pkg::MAG_W]) ||
          (|mag[1][vna_pkg::VEC_W-1:vna_pkg::MAG_W]) ||
          (|mag[2][vna_pkg::VEC_W-1:vna_pkg::MAG_W]);
    allzero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
    trial = rr + rb;
    len = (rr[31:0] == '0) ? 32'd1 : rr[31:0];
    rem_ge = rem >= dv;
    qn = {quot[vna_pkg::FRAC_W-1:0], rem_ge};
    qclip = ({1'b0, qn} > vna_pkg::NRM_W'(vna_pkg::UNIT_ONE)) ?
            vna_pkg::NRM_W'(vna_pkg::UNIT_ONE) : {1'b0, qn};
    nval = neg[cnt] ? -qclip : qclip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            mag[0] <= vx[vna_pkg::VEC_W-1] ? -vx : vx;
            mag[1] <= vy[vna_pkg::VEC_W-1] ? -vy : vy;
            mag[2] <= vz[vna_pkg::VEC_W-1] ? -vz : vz;
            neg <= {vz[vna_pkg::VEC_W-1], vy[vna_pkg::VEC_W-1], vx[vna_pkg::VEC_W-1]};
            state <= U_NORM;
          end
        end
        U_NORM: begin
          if (big) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else if (allzero) begin
            res <= '0;
            done <= 1'b1;
            state <= U_IDLE;
          end else begin
            cnt <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt != 2'd3) begin
            sq <= mag[cnt][vna_pkg::MAG_W-1:0] * mag[cnt][vna_pkg::MAG_W-1:0];
          end
          case (cnt)
            2'd0: acc <= '0;
            2'd1: acc <= {2'b00, sq};
            2'd2: acc <= acc + {2'b00, sq};
            default: begin
              rs <= acc + {2'b00, sq};
              rr <= '0;
              rb <= (2*vna_pkg::MAG_W+2)'(1) << (2*vna_pkg::MAG_W);
              state <= U_ROOT;
            end
          endcase
          cnt <= cnt + 1'b1;
        end
        U_ROOT: begin
          if (rs >= trial) begin
            rs <= rs - trial;
            rr <= (rr >> 1) + rb;
          end else begin
            rr <= rr >> 1;
          end
          rb <= rb >> 2;
          if (rb[0]) begin
            cnt <= '0;
            di <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          if (di == '0) begin
            rem <= {2'b00, mag[cnt][vna_pkg::MAG_W-1:0], {vna_pkg::FRAC_W{1'b0}}} +
                   {{(vna_pkg::MAG_W+vna_pkg::FRAC_W-29){1'b0}}, len[31:1]};
            dv <= {len, {vna_pkg::FRAC_W{1'b0}}};
            quot <= '0;
            di <= 4'd1;
          end else begin
            if (rem_ge) begin
              rem <= rem - dv;
            end
            dv <= dv >> 1;
            quot <= qn;
            if (di == 4'(vna_pkg::FRAC_W + 1)) begin
              case (cnt)
                2'd0: res.x <= nval;
                2'd1: res.y <= nval;
                default: res.z <= nval;
              endcase
              di <= '0;
              cnt <= cnt + 1'b1;
              if (cnt == 2'd2) begin
                res.nz <= 1'b1;
                done <= 1'b1;
                state <= U_IDLE;
              end
            end else begin
              di <= di + 1'b1;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == U_IDLE)
    else $error("start while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |=> (res.x <= 16'sd16384 && res.x >= -16'sd16384 &&
              res.y <= 16'sd16384 && res.y >= -16'sd16384 &&
              res.z <= 16'sd16384 && res.z >= -16'sd16384))
    else $error("component out of unit range");

endmodule

/* design/vna_back.sv */
module vna_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  vna_pkg::cmd_t                    cmd_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z,
  output logic [vna_pkg::IDX_W-1:0]        normal_index,
  output logic                             zero_normal
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_WRITE  = 10'b0000000010,
    S_FETCH  = 10'b0000000100,
    S_EDGE   = 10'b0000001000,
    S_CROSS  = 10'b0000010000,
    S_UNIT   = 10'b0000100000,
    S_SUMRD  = 10'b0001000000,
    S_SUMWR  = 10'b0010000000,
    S_READ   = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_t;

  localparam int PW = 3 * vna_pkg::POS_W;
  localparam int SW = 3 * vna_pkg::SUM_W;

  state_t state;
  vna_pkg::cmd_t cmd;
  logic [2:0] cnt;
  logic [1:0] k;

  logic [PW-1:0] pos_mem [vna_pkg::VERTEX_COUNT];
  logic [SW-1:0] sum_mem [vna_pkg::VERTEX_COUNT];
  logic [PW-1:0] pos_rd;
  logic [SW-1:0] sum_rd;
  logic pos_we;
  logic sum_we;
  logic [vna_pkg::IDX_W-1:0] pos_raddr;
  logic [vna_pkg::IDX_W-1:0] sum_addr;
  logic [vna_pkg::IDX_W-1:0] corner_k;
  logic [SW-1:0] sum_wdata;

  logic [PW-1:0] pa;
  logic [PW-1:0] pb;
  logic [PW-1:0] pc;
  logic signed [vna_pkg::POS_W:0] e1x, e1y, e1z, e2x, e2y, e2z, opa, opb;
  logic signed [2*vna_pkg::POS_W+1:0] prod;
  logic signed [2*vna_pkg::POS_W+2:0] crx, cry, crz;
  logic signed [vna_pkg::SUM_W-1:0] sx, sy, sz;

  logic unit_start;
  logic unit_done;
  vna_pkg::vcomp_t ux, uy, uz;
  vna_pkg::unit_res_t ures;

  function automatic logic signed [vna_pkg::SUM_W-1:0] sat_add(
    input logic signed [vna_pkg::SUM_W-1:0] s,
    input logic signed [vna_pkg::NRM_W-1:0] n
  );
    logic signed [vna_pkg::SUM_W:0] r;
    r = {s[vna_pkg::SUM_W-1], s} +
        {{(vna_pkg::SUM_W+1-vna_pkg::NRM_W){n[vna_pkg::NRM_W-1]}}, n};
    if (r[vna_pkg::SUM_W] != r[vna_pkg::SUM_W-1]) begin
      sat_add = r[vna_pkg::SUM_W] ? {1'b1, {(vna_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(vna_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add = r[vna_pkg::SUM_W-1:0];
    end
  endfunction

  vna_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .vx    (ux),
    .vy    (uy),
    .vz    (uz),
    .done  (unit_done),
    .res   (ures)
  );

  always_comb begin
    case (cnt[1:0])
      2'd0: pos_raddr = cmd.a;
      2'd1: pos_raddr = cmd.b;
      default: pos_raddr = cmd.c;
    endcase
    case (k)
      2'd0: corner_k = cmd.a;
      2'd1: corner_k = cmd.b;
      default: corner_k = cmd.c;
    endcase
    sum_addr = (cmd.op == vna_pkg::OP_TRI) ? corner_k : cmd.idx;
    sx = sum_rd[SW-1 -: vna_pkg::SUM_W];
    sy = sum_rd[2*vna_pkg::SUM_W-1 -: vna_pkg::SUM_W];
    sz = sum_rd[vna_pkg::SUM_W-1:0];
    pos_we = state == S_WRITE;
    sum_we = (state == S_WRITE) || (state == S_SUMWR);
    if (state == S_WRITE) begin
      sum_wdata = '0;
    end else begin
      sum_wdata = {sat_add(sx, ures.x), sat_add(sy, ures.y), sat_add(sz, ures.z)};
    end
    case (cnt)
      3'd0: begin opa = e1y; opb = e2z; end
      3'd1: begin opa = e1z; opb = e2y; end
      3'd2: begin opa = e1z; opb = e2x; end
      3'd3: begin opa = e1x; opb = e2z; end
      3'd4: begin opa = e1x; opb = e2y; end
      3'd5: begin opa = e1y; opb = e2x; end
      default: begin opa = '0; opb = '0; end
    endcase
    unit_start = ((state == S_CROSS) && (cnt == 3'd7)) || ((state == S_READ) && (cnt == 3'd1));
    if (cmd.op == vna_pkg::OP_TRI) begin
      ux = {crx[2*vna_pkg::POS_W+2], crx};
      uy = {cry[2*vna_pkg::POS_W+2], cry};
      uz = {crz[2*vna_pkg::POS_W+2], crz};
    end else begin
      ux = {{(vna_pkg::VEC_W-vna_pkg::SUM_W){sx[vna_pkg::SUM_W-1]}}, sx};
      uy = {{(vna_pkg::VEC_W-vna_pkg::SUM_W){sy[vna_pkg::SUM_W-1]}}, sy};
      uz = {{(vna_pkg::VEC_W-vna_pkg::SUM_W){sz[vna_pkg::SUM_W-1]}}, sz};
    end
  end

  assign cmd_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[cmd.idx] <= {cmd.x, cmd.y, cmd.z};
    end
    pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rd <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd <= cmd_in;
            cnt <= '0;
            k <= '0;
            case (cmd_in.op)
              vna_pkg::OP_WRITE: state <= S_WRITE;
              vna_pkg::OP_TRI: state <= S_FETCH;
              default: state <= cmd_in.miss ? S_RESULT : S_READ;
            endcase
          end
        end
        S_WRITE: state <= S_IDLE;
        S_FETCH: begin
          case (cnt)
            3'd1: pa <= pos_rd;
            3'd2: pb <= pos_rd;
            3'd3: pc <= pos_rd;
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt == 3'd3) begin
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          e1x <= {pb[PW-1], pb[PW-1 -: 16]} - {pa[PW-1], pa[PW-1 -: 16]};
          e1y <= {pb[31], pb[31:16]} - {pa[31], pa[31:16]};
          e1z <= {pb[15], pb[15:0]} - {pa[15], pa[15:0]};
          e2x <= {pc[PW-1], pc[PW-1 -: 16]} - {pa[PW-1], pa[PW-1 -: 16]};
          e2y <= {pc[31], pc[31:16]} - {pa[31], pa[31:16]};
          e2z <= {pc[15], pc[15:0]} - {pa[15], pa[15:0]};
          cnt <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          prod <= opa * opb;
          case (cnt)
            3'd1: crx <= {prod[2*vna_pkg::POS_W+1], prod};
            3'd2: crx <= crx - {prod[2*vna_pkg::POS_W+1], prod};
            3'd3: cry <= {prod[2*vna_pkg::POS_W+1], prod};
            3'd4: cry <= cry - {prod[2*vna_pkg::POS_W+1], prod};
            3'd5: crz <= {prod[2*vna_pkg::POS_W+1], prod};
            3'd6: crz <= crz - {prod[2*vna_pkg::POS_W+1], prod};
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt == 3'd7) begin
            state <= S_UNIT;
          end
        end
        S_READ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd1) begin
            state <= S_UNIT;
          end
        end
        S_UNIT: begin
          if (unit_done) begin
            if (cmd.op != vna_pkg::OP_TRI) begin
              state <= S_RESULT;
            end else if (ures.nz) begin
              state <= S_SUMRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SUMRD: state <= S_SUMWR;
        S_SUMWR: begin
          k <= k + 1'b1;
          state <= (k == 2'd2) ? S_IDLE : S_SUMRD;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            normal_index <= cmd.idx;
            if (cmd.miss) begin
              normal_x <= '0;
              normal_y <= '0;
              normal_z <= '0;
              zero_normal <= 1'b1;
            end else begin
              normal_x <= ures.x;
              normal_y <= ures.y;
              normal_z <= ures.z;
              zero_normal <= !ures.nz;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/vertex_normal_accumulator_top.sv */
// channel  handshake            payload
// input    in_valid / in_ready  kind, vertex_index, pos_x/y/z, corner_a/b/c
// output   out_valid/out_ready  normal_x/y/z, normal_index, zero_normal
//
// Reads and triangles use the shared unit-length unit: a 31-step square root runs once,
// then a 15-step divider with a load step runs once per component, one bit per cycle.
// A four-entry command queue takes transactions while the back end is busy.
// Reset leaves the position and sum memories unset; reset only clears control.
// A result waiting on out_ready holds the back end at its next read.
module vertex_normal_accumulator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [vna_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z,
  input  logic [vna_pkg::IDX_W-1:0]        corner_a,
  input  logic [vna_pkg::IDX_W-1:0]        corner_b,
  input  logic [vna_pkg::IDX_W-1:0]        corner_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z,
  output logic [vna_pkg::IDX_W-1:0]        normal_index,
  output logic                             zero_normal
);

  logic deq_valid;
  logic deq_ready;
  vna_pkg::cmd_t deq_cmd;

  vna_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .deq_valid    (deq_valid),
    .deq_ready    (deq_ready),
    .deq_cmd      (deq_cmd)
  );

  vna_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (deq_valid),
    .cmd_ready    (deq_ready),
    .cmd_in       (deq_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .normal_index (normal_index),
    .zero_normal  (zero_normal)
  );

endmodule

/* test/vertex_normal_accumulator_checker.sv */
`timescale 1ns / 100ps

module vertex_normal_accumulator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [vna_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z,
  input  logic [vna_pkg::IDX_W-1:0]        corner_a,
  input  logic [vna_pkg::IDX_W-1:0]        corner_b,
  input  logic [vna_pkg::IDX_W-1:0]        corner_c,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [vna_pkg::NRM_W-1:0] normal_x,
  input  logic signed [vna_pkg::NRM_W-1:0] normal_y,
  input  logic signed [vna_pkg::NRM_W-1:0] normal_z,
  input  logic [vna_pkg::IDX_W-1:0]        normal_index,
  input  logic                             zero_normal,
  output int                               failures,
  output int                               pending
);

  localparam int SUM_HI = 2097151;
  localparam int SUM_LO = -2097152;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [vna_pkg::NRM_W-1:0] x;
    logic signed [vna_pkg::NRM_W-1:0] y;
    logic signed [vna_pkg::NRM_W-1:0] z;
    logic [vna_pkg::IDX_W-1:0]        idx;
    logic                             zero;
  } normal_t;

  logic signed [vna_pkg::POS_W-1:0] vtx_pos [vna_pkg::VERTEX_COUNT][3];
  int                               vtx_sum [vna_pkg::VERTEX_COUNT][3];
  normal_t                          expected_normals [$];

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_length(input vec3_t v, output vec3_t n);
    longint unsigned mag [3];
    longint unsigned m;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    int sh;
    m = 0;
    sq = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
      n[i] = 0;
    end
    if (m == 0) return 1'b0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sq += mag[i] * mag[i];
    end
    len = root_floor(sq);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * vna_pkg::UNIT_ONE + len / 2) / len;
      if (q > vna_pkg::UNIT_ONE) q = vna_pkg::UNIT_ONE;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic int clamp_add(input int s, input longint d);
    longint r;
    r = longint'(s) + d;
    if (r > SUM_HI) r = SUM_HI;
    if (r < SUM_LO) r = SUM_LO;
    return int'(r);
  endfunction

  task automatic compare(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic apply_triangle(input int a, input int b, input int c);
    vec3_t e1, e2, cr, n;
    int corner [3];
    corner = '{a, b, c};
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(vtx_pos[b][i]) - longint'(vtx_pos[a][i]);
      e2[i] = longint'(vtx_pos[c][i]) - longint'(vtx_pos[a][i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (unit_length(cr, n)) begin
      foreach (corner[k])
        for (int i = 0; i < 3; i++)
          vtx_sum[corner[k]][i] = clamp_add(vtx_sum[corner[k]][i], n[i]);
    end
  endtask

  function automatic normal_t read_normal(input int idx);
    vec3_t v, n;
    normal_t r;
    for (int i = 0; i < 3; i++) v[i] = vtx_sum[idx][i];
    r.zero = !unit_length(v, n);
    r.x = vna_pkg::NRM_W'(n[0]);
    r.y = vna_pkg::NRM_W'(n[1]);
    r.z = vna_pkg::NRM_W'(n[2]);
    r.idx = vna_pkg::IDX_W'(idx);
    return r;
  endfunction

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    normal_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          $error("normal_index: expected none, got %0d", normal_index);
          failures++;
        end else begin
          want = expected_normals.pop_front();
          compare("normal_x", want.x, normal_x);
          compare("normal_y", want.y, normal_y);
          compare("normal_z", want.z, normal_z);
          compare("normal_index", want.idx, normal_index);
          compare("zero_normal", want.zero, zero_normal);
        end
      end
      if (in_valid && in_ready) begin
        case (kind)
          vna_pkg::OP_WRITE: if (vna_pkg::idx_ok(vertex_index)) begin
            vtx_pos[vertex_index] = '{pos_x, pos_y, pos_z};
            vtx_sum[vertex_index] = '{0, 0, 0};
          end
          vna_pkg::OP_TRI: if (vna_pkg::idx_ok(corner_a) && vna_pkg::idx_ok(corner_b) &&
                               vna_pkg::idx_ok(corner_c))
            apply_triangle(corner_a, corner_b, corner_c);
          vna_pkg::OP_READ: begin
            if (vna_pkg::idx_ok(vertex_index)) begin
              want = read_normal(vertex_index);
            end else begin
              want = '{x: 0, y: 0, z: 0, idx: vertex_index, zero: 1'b1};
            end
            expected_normals = {expected_normals, want};
          end
          default: ;
        endcase
      end
      pending = expected_normals.size();
    end
  end

endmodule

/* test/vertex_normal_accumulator_top_test.sv */
`timescale 1ns / 100ps

module vertex_normal_accumulator_top_test;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [1:0]                       kind;
  logic [vna_pkg::IDX_W-1:0]        vertex_index;
  logic signed [vna_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
  logic [vna_pkg::IDX_W-1:0]        corner_a, corner_b, corner_c;
  logic                             out_valid;
  logic                             out_ready;
  logic signed [vna_pkg::NRM_W-1:0] normal_x, normal_y, normal_z;
  logic [vna_pkg::IDX_W-1:0]        normal_index;
  logic                             zero_normal;
  int                               failures;
  int                               pending;

  bit  gaps_on;
  bit  written [vna_pkg::VERTEX_COUNT];
  int  written_list [$];
  int  sent_total, sent_tri, sent_read, sent_write;

  vertex_normal_accumulator_top dut (.*);

  vertex_normal_accumulator_checker checker_i (.*);

  always #4 clk = ~clk;

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output stalls: phases of no stall, light stall and heavy stall
  always @(negedge clk) begin
    int mode;
    int hold;
    if (rst) begin
      out_ready = 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (mode == 0) begin
        out_ready = 1'b1;
      end else if ($urandom_range(0, 99) < (mode == 1 ? 20 : 50)) begin
        hold = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      n = r < 60 ? 0 : (r < 93 ? $urandom_range(1, 3) : $urandom_range(10, 60));
      if (n > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send(input logic [1:0] k, input int idx, input int x, input int y,
                      input int z, input int a, input int b, input int c);
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    vertex_index = vna_pkg::IDX_W'(idx);
    pos_x = vna_pkg::POS_W'(x);
    pos_y = vna_pkg::POS_W'(y);
    pos_z = vna_pkg::POS_W'(z);
    corner_a = vna_pkg::IDX_W'(a);
    corner_b = vna_pkg::IDX_W'(b);
    corner_c = vna_pkg::IDX_W'(c);
    do @(posedge clk); while (!in_ready);
    if (k != KIND_SPARE) sent_total++;
    idle_gap();
  endtask

  task automatic put_vertex(input int idx, input int x, input int y, input int z);
    send(vna_pkg::OP_WRITE, idx, x, y, z, $urandom, $urandom, $urandom);
    if (!written[idx]) written_list = {written_list, idx};
    written[idx] = 1'b1;
    sent_write++;
  endtask

  task automatic put_triangle(input int a, input int b, input int c);
    send(vna_pkg::OP_TRI, $urandom, $urandom, $urandom, $urandom, a, b, c);
    sent_tri++;
  endtask

  task automatic put_read(input int idx);
    send(vna_pkg::OP_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    sent_read++;
  endtask

  function automatic int any_vertex();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic int coord();
    if ($urandom_range(0, 1)) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int a, b, c, r;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = vna_pkg::OP_WRITE;
    vertex_index = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    corner_a = '0;
    corner_b = '0;
    corner_c = '0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    put_vertex(0, -32768, -32768, -32768);
    put_vertex(1023, 32767, 32767, 32767);
    put_vertex(1, 32767, -32768, 0);
    put_vertex(2, 0, 32767, -32768);
    put_vertex(3, 256, 0, 0);
    put_read(0);
    put_triangle(0, 1023, 1);
    put_triangle(0, 1, 2);
    put_triangle(1, 1, 2);
    put_triangle(0, 1023, 1023);
    put_triangle(2, 3, 1);
    send(KIND_SPARE, 5, 1, 1, 1, 0, 1, 2);
    put_read(0);
    put_read(1023);
    put_read(1);
    put_read(2);
    put_triangle(1023, 0, 3);
    put_read(3);
    put_vertex(4, 0, 0, 0);
    put_vertex(5, 512, 0, 0);
    put_vertex(6, 0, 512, 0);
    put_triangle(4, 5, 6);
    put_triangle(4, 6, 5);
    put_read(4);

    repeat (60) put_vertex($urandom_range(0, 1023), coord(), coord(), coord());

    while (sent_total < 1850) begin
      if (sent_total > 900 && sent_total < 920) begin
        drain();
        gaps_on = 1'b0;
      end
      if (sent_total > 1300) gaps_on = 1'b1;
      r = $urandom_range(0, 999);
      a = any_vertex();
      b = any_vertex();
      c = any_vertex();
      if (r < 8) begin
        // push one triangle far enough to saturate its corners
        repeat (140) put_triangle(a, b, c);
        put_read(a);
        put_read(c);
      end else if (r < 200) begin
        put_vertex($urandom_range(0, 1023), coord(), coord(), coord());
      end else if (r < 600) begin
        put_triangle(a, b, c);
      end else if (r < 620) begin
        put_triangle(a, a, c);
      end else if (r < 970) begin
        put_read(a);
      end else begin
        send(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, a, b, c);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("run covered %0d transactions: %0d vertex writes, %0d triangles, %0d reads",
             sent_total, sent_write, sent_tri, sent_read);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* vertex_normal_accumulator_top.f */
design/vna_pkg.sv
design/vna_front.sv
design/vna_unit.sv
design/vna_back.sv
design/vertex_normal_accumulator_top.sv
test/vertex_normal_accumulator_checker.sv
test/vertex_normal_accumulator_top_test.sv
